@@ design/reat_pkg.sv @@
package reat_pkg;

   localparam int SAMPLE_W = 32;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic signed [STATUS_W-1:0] status_type;

   localparam status_type STATUS_NONE = 2'sb00;
   localparam status_type STATUS_LOW  = 2'sb01;
   localparam status_type STATUS_HIGH = 2'sb11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

@@ design/reat_win_ram.sv @@
module reat_win_ram #(
   parameter int DEPTH = 18,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/range_extreme_alert_tracker_core.sv @@
// Flow: while the window fills, an accepted beat passes IDLE, then EMIT;
//   once it is full, IDLE, SCAN, then EMIT, holding the result on a stall.
// Pacing: one beat at a time, accepted only in IDLE; the scan is set by the
//   single read port of the window memory walking every entry.
// Reset: synchronous, active high; clears status, fill count, write pointer
//   and handshake state. Window contents are all written before first read.
module range_extreme_alert_tracker_core #(
   parameter int WINDOW = 18
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [reat_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] sample
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [reat_pkg::RSP_DATA_W-1:0] rsp_tdata   // [1:0] status, [7:2] zero
);

   import reat_pkg::*;

   localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);

   state_type        state_ff, state_in;
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic             rd_valid_ff, rd_last_ff;
   logic             warm_ff, warm_in;
   sample_type       sample_ff, sample_in;
   logic             low_ok_ff, low_ok_in;
   logic             high_ok_ff, high_ok_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             rd_en;
   logic             emit;
   sample_type       rd_data;
   status_type       next_status;

   reat_win_ram #(
      .DEPTH (WINDOW),
      .WIDTH (SAMPLE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wptr_ff),
      .wr_data (req_tdata[SAMPLE_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[PW-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (fill_ff == CW'(WINDOW)) ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (rd_last_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      emit       = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SCAN: rd_en = (issue_ff < CW'(WINDOW));
         ST_EMIT: emit = !rsp_valid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      next_status = status_ff;
      case (status_ff)
         STATUS_HIGH: if (low_ok_ff) next_status = STATUS_LOW;
         STATUS_LOW:  if (high_ok_ff) next_status = STATUS_HIGH;
         default: begin
            if (low_ok_ff) begin
               next_status = STATUS_LOW;
            end else if (high_ok_ff) begin
               next_status = STATUS_HIGH;
            end
         end
      endcase
   end

   always_comb begin
      wptr_in      = wptr_ff;
      fill_in      = fill_ff;
      issue_in     = issue_ff;
      warm_in      = warm_ff;
      sample_in    = sample_ff;
      low_ok_in    = low_ok_ff;
      high_ok_in   = high_ok_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         wptr_in    = (wptr_ff == PW'(WINDOW - 1)) ? '0 : wptr_ff + 1'b1;
         warm_in    = (fill_ff != CW'(WINDOW));
         if (fill_ff != CW'(WINDOW)) begin
            fill_in = fill_ff + 1'b1;
         end
         sample_in  = req_tdata[SAMPLE_W-1:0];
         issue_in   = '0;
         low_ok_in  = 1'b1;
         high_ok_in = 1'b1;
      end

      if (rd_en) begin
         issue_in = issue_ff + 1'b1;
      end

      // fold each returning window entry into the extreme flags
      if (rd_valid_ff) begin
         low_ok_in  = low_ok_ff && (sample_ff <= rd_data);
         high_ok_in = high_ok_ff && (sample_ff >= rd_data);
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         if (warm_ff) begin
            rsp_data_in = {{(RSP_DATA_W-STATUS_W){1'b0}}, $unsigned(STATUS_NONE)};
         end else begin
            status_in   = next_status;
            rsp_data_in = {{(RSP_DATA_W-STATUS_W){1'b0}}, $unsigned(next_status)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         status_ff    <= STATUS_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_en;
         rd_last_ff   <= rd_en && (issue_ff == CW'(WINDOW - 1));
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      warm_ff     <= warm_in;
      sample_ff   <= sample_in;
      low_ok_ff   <= low_ok_in;
      high_ok_ff  <= high_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ design/reat_checker.sv @@
module reat_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [reat_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import reat_pkg::*;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // status is one of the three codes, upper bits zero
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == 8'h00 || rsp_tdata == 8'h01 || rsp_tdata == 8'h03))
      else $error("bad status code");

   // one item at a time: no accept in the cycle after an accept
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back accept");

   a_rst_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an accepted beat leaves no result visible yet in the next cycle unless one waited
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

endmodule

bind range_extreme_alert_tracker_core reat_checker u_reat_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import reat_pkg::*;

   localparam int WINDOW      = 18;
   localparam int RAND_ITEMS  = 725;
   localparam int QUIET_TAIL  = 80;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      sample_type sample;
      bit         typed;
      status_type status;
   } sample_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // [31:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [1:0] status, [7:2] zero

   // handshake state as it stood just before the coming rising edge
   logic                  req_fire = 1'b0;
   logic                  rsp_fire = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_seen = '0;

   // predictor state
   sample_type  win_q [WINDOW];
   status_type  alert_q;
   int unsigned fill_q;
   int unsigned wpos_q;

   status_type  status_q [$];
   int          errors = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;
   bit          drv_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int          stall_left = 0;

   // first sample is an outlier, the rest of the warm-up is flat, so the first
   // scored beat sees a flat window and the low test wins from no alert
   sample_row dir_tab [0:24] = '{
      '{32'hFFFF_FFFF, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_NONE},
      '{32'hA5A5_5A5A, 1'b1, STATUS_LOW},
      '{32'hFFFF_FFFF, 1'b1, STATUS_HIGH},
      '{32'h0000_0000, 1'b1, STATUS_LOW},
      '{32'hFFFF_FFFF, 1'b1, STATUS_HIGH},
      '{32'h5555_5555, 1'b1, STATUS_HIGH},
      '{32'hFFFF_FFFF, 1'b1, STATUS_HIGH},
      '{32'h0000_0000, 1'b1, STATUS_LOW}
   };

   range_extreme_alert_tracker_core #(
      .WINDOW(WINDOW)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      req_fire <= req_tvalid && req_tready;
      rsp_fire <= rsp_tvalid && rsp_tready;
      rsp_seen <= rsp_tdata;
   end

   // store the sample, then score it against the window extremes once full
   function automatic status_type next_alert(input sample_type s);
      sample_type hi;
      sample_type lo;
      logic       at_low;
      logic       at_high;
      int         i;
      win_q[wpos_q] = s;
      wpos_q = (wpos_q + 1) % WINDOW;
      if (fill_q < WINDOW) begin
         fill_q++;
         return STATUS_NONE;
      end
      hi = win_q[0];
      lo = win_q[0];
      for (i = 1; i < WINDOW; i++) begin
         if (win_q[i] > hi) hi = win_q[i];
         if (win_q[i] < lo) lo = win_q[i];
      end
      at_low  = (s <= lo);
      at_high = (s >= hi);
      case (alert_q)
         STATUS_HIGH: begin
            if (at_low) alert_q = STATUS_LOW;
         end
         STATUS_LOW: begin
            if (at_high) alert_q = STATUS_HIGH;
         end
         default: begin
            if (at_low) alert_q = STATUS_LOW;
            else if (at_high) alert_q = STATUS_HIGH;
         end
      endcase
      return alert_q;
   endfunction

   task automatic send_sample(input sample_type s, input bit typed, input status_type st);
      status_type want;
      if (!quiet && !drv_calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (req_fire !== 1'b1);
      want = next_alert(s);
      status_q.push_back(typed ? st : want);
   endtask

   // result side: random stall bursts, with calm stretches
   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) rsp_calm <= !rsp_calm;
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 11);
      end
   end

   always @(posedge clock) begin
      if (rsp_fire === 1'b1) begin
         if (status_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat, status %0d",
                                       $signed(rsp_seen[STATUS_W-1:0]));
         end else if (rsp_seen[STATUS_W-1:0] !== status_q[0]) begin
            errors++;
            if (errors <= 10) $display("status mismatch: expected %0d, got %0d",
                                       status_q[0], $signed(rsp_seen[STATUS_W-1:0]));
            void'(status_q.pop_front());
         end else begin
            void'(status_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      int         n;
      int         kind;
      int         len;
      int         k;
      sample_type base;
      sample_type step;
      sample_type s;
      for (k = 0; k < WINDOW; k++) win_q[k] = '0;
      alert_q = STATUS_NONE;
      fill_q  = 0;
      wpos_q  = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_sample(dir_tab[i].sample, dir_tab[i].typed, dir_tab[i].status);

      // random part: runs of shaped data so the window sees ramps, plateaus and ties
      n = 0;
      while (n < RAND_ITEMS) begin
         kind     = $urandom_range(0, 5);
         len      = (kind == 0) ? $urandom_range(10, 30) : $urandom_range(1, 30);
         base     = $urandom;
         step     = $urandom_range(1, 1000);
         drv_calm = ($urandom_range(0, 3) == 0);
         for (k = 0; k < len && n < RAND_ITEMS; k++) begin
            case (kind)
               0: s = base;
               1: s = base + k * step;
               2: s = base - k * step;
               3: s = base + $urandom_range(0, 3);
               4: s = $urandom;
               default: s = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            endcase
            if (n >= RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
            send_sample(s, 1'b0, STATUS_NONE);
            n++;
         end
      end
      req_tvalid <= 1'b0;

      while (status_q.size() != 0) @(posedge clock);
      repeat (WINDOW + 10) @(posedge clock);
      if (errors == 0 && status_q.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/reat_pkg.sv
design/reat_win_ram.sv
design/range_extreme_alert_tracker_core.sv
design/reat_checker.sv
verif/tb.sv
